>>> rtl/qam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qam_pkg;

    localparam int NUM_COEFS = 13;

    typedef logic signed [63:0] t_word;

    localparam t_word WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // item modes
    localparam logic [2:0] MODE_CLEAR = 3'd0;
    localparam logic [2:0] MODE_ADD   = 3'd1;
    localparam logic [2:0] MODE_SCALE = 3'd2;
    localparam logic [2:0] MODE_EVAL  = 3'd3;
    localparam logic [2:0] MODE_MIN   = 3'd4;

    // operand codes: below 32 a scratch memory address, else a special source
    typedef logic [5:0] t_src;
    localparam t_src SRC_D    = 6'd13;
    localparam t_src SRC_N    = 6'd14;
    localparam t_src SRC_T0   = 6'd15;
    localparam t_src SRC_T1   = 6'd16;
    localparam t_src SRC_T2   = 6'd17;
    localparam t_src SRC_COF  = 6'd18;
    localparam t_src SRC_P0   = 6'd32;
    localparam t_src SRC_P1   = 6'd33;
    localparam t_src SRC_P2   = 6'd34;
    localparam t_src SRC_VAL  = 6'd35;
    localparam t_src SRC_ZERO = 6'd36;

    typedef enum logic [2:0] {
        OP_END, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CLR, OP_CHK, OP_OUTE
    } t_op;

    typedef struct packed {
        t_op        op;
        t_src       a;
        t_src       b;
        logic [4:0] dst;
    } t_uop;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_DONE
    } t_state;

    typedef struct packed {
        logic  done;
        logic  sat;
        t_word value;
    } t_mul_res;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [31:0] value;
    } t_div_res;

    function automatic logic [63:0] mag64(input t_word x);
        return x[63] ? -x : x;
    endfunction

    function automatic t_uop mk(input t_op op, input t_src a, input t_src b, input t_src d);
        t_uop u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = d[4:0];
        return u;
    endfunction

    // matrix entry with wrapped row and column
    function automatic t_src msrc(input int r, input int c);
        return t_src'(3 * (r % 3) + (c % 3));
    endfunction

    function automatic t_src csrc(input int r, input int c);
        return t_src'(18 + 3 * r + c);
    endfunction

    function automatic t_src psrc(input int i);
        return t_src'(32 + i);
    endfunction

    // microprogram: one step per pc value for each mode
    function automatic t_uop uop_fetch(input logic [2:0] mode, input logic [3:0] idx,
                                       input logic [5:0] pc);
        t_uop u;
        u = mk(OP_END, SRC_ZERO, SRC_ZERO, SRC_ZERO);
        case (mode)
            MODE_CLEAR: begin
                if (pc == 6'd0) u = mk(OP_CLR, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            end
            MODE_ADD: begin
                if (pc == 6'd0 && idx < 4'(NUM_COEFS))
                    u = mk(OP_ADD, t_src'(idx), SRC_VAL, t_src'(idx));
            end
            MODE_SCALE: begin
                if (pc < 6'(NUM_COEFS)) u = mk(OP_MUL, pc, SRC_VAL, pc);
            end
            MODE_EVAL: begin
                if (pc == 6'd0) u = mk(OP_ADD, t_src'(12), SRC_ZERO, SRC_T0);
                for (int i = 0; i < 3; i++) begin
                    if (pc == 6'(1 + 9 * i)) u = mk(OP_MUL, msrc(i, 0), SRC_P0, SRC_T1);
                    if (pc == 6'(2 + 9 * i)) u = mk(OP_MUL, msrc(i, 1), SRC_P1, SRC_T2);
                    if (pc == 6'(3 + 9 * i)) u = mk(OP_ADD, SRC_T1, SRC_T2, SRC_T1);
                    if (pc == 6'(4 + 9 * i)) u = mk(OP_MUL, msrc(i, 2), SRC_P2, SRC_T2);
                    if (pc == 6'(5 + 9 * i)) u = mk(OP_ADD, SRC_T1, SRC_T2, SRC_T1);
                    if (pc == 6'(6 + 9 * i)) u = mk(OP_MUL, psrc(i), SRC_T1, SRC_T2);
                    if (pc == 6'(7 + 9 * i)) u = mk(OP_ADD, SRC_T0, SRC_T2, SRC_T0);
                    if (pc == 6'(8 + 9 * i)) u = mk(OP_MUL, t_src'(9 + i), psrc(i), SRC_T2);
                    if (pc == 6'(9 + 9 * i)) u = mk(OP_ADD, SRC_T0, SRC_T2, SRC_T0);
                end
                if (pc == 6'd28) u = mk(OP_OUTE, SRC_T0, SRC_ZERO, SRC_ZERO);
            end
            MODE_MIN: begin
                // cofactors
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        if (pc == 6'(9 * r + 3 * c))
                            u = mk(OP_MUL, msrc(r + 1, c + 1), msrc(r + 2, c + 2), SRC_T0);
                        if (pc == 6'(9 * r + 3 * c + 1))
                            u = mk(OP_MUL, msrc(r + 1, c + 2), msrc(r + 2, c + 1), SRC_T1);
                        if (pc == 6'(9 * r + 3 * c + 2))
                            u = mk(OP_SUB, SRC_T0, SRC_T1, csrc(r, c));
                    end
                end
                // determinant along row 0
                if (pc == 6'd27) u = mk(OP_MUL, msrc(0, 0), csrc(0, 0), SRC_D);
                if (pc == 6'd28) u = mk(OP_MUL, msrc(0, 1), csrc(0, 1), SRC_T0);
                if (pc == 6'd29) u = mk(OP_ADD, SRC_D, SRC_T0, SRC_D);
                if (pc == 6'd30) u = mk(OP_MUL, msrc(0, 2), csrc(0, 2), SRC_T0);
                if (pc == 6'd31) u = mk(OP_ADD, SRC_D, SRC_T0, SRC_D);
                if (pc == 6'd32) u = mk(OP_CHK, SRC_D, SRC_ZERO, SRC_ZERO);
                // adjugate times vector, then divide
                for (int i = 0; i < 3; i++) begin
                    if (pc == 6'(33 + 6 * i)) u = mk(OP_MUL, csrc(0, i), t_src'(9), SRC_N);
                    if (pc == 6'(34 + 6 * i)) u = mk(OP_MUL, csrc(1, i), t_src'(10), SRC_T0);
                    if (pc == 6'(35 + 6 * i)) u = mk(OP_ADD, SRC_N, SRC_T0, SRC_N);
                    if (pc == 6'(36 + 6 * i)) u = mk(OP_MUL, csrc(2, i), t_src'(11), SRC_T0);
                    if (pc == 6'(37 + 6 * i)) u = mk(OP_ADD, SRC_N, SRC_T0, SRC_N);
                    if (pc == 6'(38 + 6 * i)) u = mk(OP_DIV, SRC_N, SRC_D, t_src'(i));
                end
            end
            default: ;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/qam_if.sv
`timescale 1ns / 1ps
`default_nettype none

// input items
interface qam_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic [3:0]        coef_index;
    logic signed [31:0] value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, mode, coef_index, value, point_x, point_y, point_z,
                    input ready);
    modport sink (input valid, mode, coef_index, value, point_x, point_y, point_z,
                  output ready);
endinterface

// result items
interface qam_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] energy;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic              singular;
    logic              overflow;

    modport source (output valid, energy, min_x, min_y, min_z, singular, overflow,
                    input ready);
    modport sink (input valid, energy, min_x, min_y, min_z, singular, overflow,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/quadric_accumulate_minimize_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Quadric accumulator/minimizer. Holds a 3x3 matrix, a 3-vector and a scalar
// (13 signed fixed-point coefficients) and runs one item at a time through a
// microcoded sequencer sharing one adder, one iterative multiplier (four 32x32
// partial products) and one bit-serial divider. A minimize item runs three
// divisions; with a singular matrix it ends after the determinant. The input
// is ready only while idle; a finished result waits in an output register, so
// the next item can be accepted before it is taken.
module quadric_accumulate_minimize_core
    import qam_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qam_in_if.sink     i_in,
    qam_out_if.source  o_out
);

    localparam int MEM_DEPTH = 27;
    localparam t_word COEF_MAX = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
    localparam t_word COEF_MIN = -COEF_MAX - 64'sd1;
    localparam t_word OUT_MAX  = 64'sd2147483647;
    localparam t_word OUT_MIN  = -64'sd2147483648;
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;

    t_state r_state, n_state;
    logic [5:0] r_pc, n_pc;
    t_uop r_uop, w_uop;

    logic [2:0]         r_mode;
    logic [3:0]         r_idx;
    logic signed [31:0] r_val, r_px, r_py, r_pz;

    // coefficients at 0..12, scratch above; coefficients carry valid bits
    t_word r_mem [MEM_DEPTH];
    logic [NUM_COEFS-1:0] r_cvld;
    t_word r_rda, r_rdb;
    logic  r_vla, r_vlb;

    t_word w_opa, w_opb;
    logic signed [64:0] w_sum;
    t_word w_alu;
    logic  w_alu_sat;

    logic       w_we;
    logic [4:0] w_waddr;
    t_word      w_wraw, w_wdata;
    logic       w_wsat, w_csat;
    logic       w_esat;
    logic [31:0] w_energy;

    logic [31:0] r_energy, r_mx, r_my, r_mz;
    logic        r_sing, r_ovf;

    logic        r_out_valid;
    logic [31:0] r_o_energy, r_o_mx, r_o_my, r_o_mz;
    logic        r_o_sing, r_o_ovf;

    logic w_accept, w_load, w_mul_start, w_div_start, w_unit_done;
    t_mul_res w_mul;
    t_div_res w_div;

    function automatic t_word pick(input t_src s, input t_word rd, input logic v,
                                   input logic signed [31:0] px, input logic signed [31:0] py,
                                   input logic signed [31:0] pz, input logic signed [31:0] val);
        t_word x;
        case (s)
            SRC_P0:  x = t_word'(px);
            SRC_P1:  x = t_word'(py);
            SRC_P2:  x = t_word'(pz);
            SRC_VAL: x = t_word'(val);
            default: x = (!s[5] && v) ? rd : '0;
        endcase
        return x;
    endfunction

    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign w_uop    = uop_fetch(r_mode, r_idx, r_pc);

    // operands
    assign w_opa = pick(r_uop.a, r_rda, r_vla, r_px, r_py, r_pz, r_val);
    assign w_opb = pick(r_uop.b, r_rdb, r_vlb, r_px, r_py, r_pz, r_val);

    // saturating add/subtract
    always_comb begin
        if (r_uop.op == OP_SUB)
            w_sum = {w_opa[63], w_opa} - {w_opb[63], w_opb};
        else
            w_sum = {w_opa[63], w_opa} + {w_opb[63], w_opb};
        w_alu_sat = 1'b0;
        w_alu     = w_sum[63:0];
        if (w_sum > SUM_MAX) begin
            w_alu_sat = 1'b1;
            w_alu     = WIDE_MAX;
        end else if (w_sum < SUM_MIN) begin
            w_alu_sat = 1'b1;
            w_alu     = -WIDE_MAX;
        end
    end

    // energy output saturation
    always_comb begin
        w_esat   = 1'b0;
        w_energy = w_opa[31:0];
        if (w_opa > OUT_MAX) begin
            w_esat   = 1'b1;
            w_energy = OUT_MAX[31:0];
        end else if (w_opa < OUT_MIN) begin
            w_esat   = 1'b1;
            w_energy = OUT_MIN[31:0];
        end
    end

    // shared units
    assign w_mul_start = (r_state == ST_EXEC) && (r_uop.op == OP_MUL);
    assign w_div_start = (r_state == ST_EXEC) && (r_uop.op == OP_DIV);
    assign w_unit_done = (r_uop.op == OP_MUL) ? w_mul.done : w_div.done;

    qam_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_res   (w_mul)
    );

    qam_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_opa),
        .i_den   (w_opb),
        .o_res   (w_div)
    );

    // scratch write port, coefficients clamped to their width
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_uop.dst;
        w_wraw  = w_alu;
        w_wsat  = w_alu_sat;
        if (r_state == ST_EXEC && (r_uop.op == OP_ADD || r_uop.op == OP_SUB)) begin
            w_we = 1'b1;
        end else if (r_state == ST_WAIT && r_uop.op == OP_MUL && w_mul.done) begin
            w_we   = 1'b1;
            w_wraw = w_mul.value;
            w_wsat = w_mul.sat;
        end
        w_csat  = 1'b0;
        w_wdata = w_wraw;
        if (w_waddr < 5'(NUM_COEFS)) begin
            if (w_wraw > COEF_MAX) begin
                w_csat  = 1'b1;
                w_wdata = COEF_MAX;
            end else if (w_wraw < COEF_MIN) begin
                w_csat  = 1'b1;
                w_wdata = COEF_MIN;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_FETCH;
                    n_pc    = '0;
                end
            end
            ST_FETCH: n_state = ST_EXEC;
            ST_EXEC: begin
                case (r_uop.op)
                    OP_ADD, OP_SUB, OP_OUTE: begin
                        n_pc    = r_pc + 6'd1;
                        n_state = ST_FETCH;
                    end
                    OP_MUL, OP_DIV: n_state = ST_WAIT;
                    OP_CHK: begin
                        if (w_opa == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            n_pc    = r_pc + 6'd1;
                            n_state = ST_FETCH;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_WAIT: begin
                if (w_unit_done) begin
                    n_pc    = r_pc + 6'd1;
                    n_state = ST_FETCH;
                end
            end
            ST_DONE: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_cvld      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (r_state == ST_EXEC && r_uop.op == OP_CLR)
                r_cvld <= '0;
            else if (w_we && w_waddr < 5'(NUM_COEFS))
                r_cvld[w_waddr[3:0]] <= 1'b1;
            if (w_load)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    // scratch memory, registered reads at fetch
    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[w_waddr] <= w_wdata;
        if (r_state == ST_FETCH) begin
            r_uop <= w_uop;
            if (!w_uop.a[5]) r_rda <= r_mem[w_uop.a[4:0]];
            if (!w_uop.b[5]) r_rdb <= r_mem[w_uop.b[4:0]];
            r_vla <= (w_uop.a >= t_src'(NUM_COEFS)) || r_cvld[w_uop.a[3:0]];
            r_vlb <= (w_uop.b >= t_src'(NUM_COEFS)) || r_cvld[w_uop.b[3:0]];
        end
    end

    // item capture, working results, output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_in.mode;
            r_idx    <= i_in.coef_index;
            r_val    <= i_in.value;
            r_px     <= i_in.point_x;
            r_py     <= i_in.point_y;
            r_pz     <= i_in.point_z;
            r_energy <= '0;
            r_mx     <= '0;
            r_my     <= '0;
            r_mz     <= '0;
            r_sing   <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (w_we && (w_wsat || w_csat))
                r_ovf <= 1'b1;
            if (r_state == ST_EXEC && r_uop.op == OP_OUTE) begin
                r_energy <= w_energy;
                if (w_esat) r_ovf <= 1'b1;
            end
            if (r_state == ST_EXEC && r_uop.op == OP_CHK && w_opa == '0)
                r_sing <= 1'b1;
            if (r_state == ST_WAIT && r_uop.op == OP_DIV && w_div.done) begin
                case (r_uop.dst[1:0])
                    2'd0:    r_mx <= w_div.value;
                    2'd1:    r_my <= w_div.value;
                    default: r_mz <= w_div.value;
                endcase
                if (w_div.sat) r_ovf <= 1'b1;
            end
        end
        if (w_load) begin
            r_o_energy <= r_energy;
            r_o_mx     <= r_mx;
            r_o_my     <= r_my;
            r_o_mz     <= r_mz;
            r_o_sing   <= r_sing;
            r_o_ovf    <= r_ovf;
        end
    end

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.energy   = r_o_energy;
    assign o_out.min_x    = r_o_mx;
    assign o_out.min_y    = r_o_my;
    assign o_out.min_z    = r_o_mz;
    assign o_out.singular = r_o_sing;
    assign o_out.overflow = r_o_ovf;

endmodule

`default_nettype wire

>>> rtl/qam_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// 64x64 signed fixed-point multiply from four 32x32 partial products
module qam_mul
    import qam_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_word    i_a,
    input  wire t_word    i_b,
    output t_mul_res      o_res
);

    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_cnt;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_pp;
    logic [63:0]  w_mag;
    logic         w_sat;

    // partial product halves picked by step
    assign w_ah = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign w_bh = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
    assign w_pp = w_ah * w_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_ua   <= mag64(i_a);
                r_ub   <= mag64(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp <= w_pp;
                    r_sh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                end
                if (r_cnt != 3'd0)
                    r_acc <= r_acc + ({64'b0, r_pp} << {r_sh, 5'b0});
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // drop fraction bits, saturate magnitude, apply sign
    assign w_sat = |r_acc[127:63+FRAC_BITS];
    assign w_mag = w_sat ? WIDE_MAX : r_acc[63+FRAC_BITS:FRAC_BITS];

    assign o_res.done  = r_done;
    assign o_res.sat   = w_sat;
    assign o_res.value = r_neg ? -w_mag : w_mag;

endmodule

`default_nettype wire

>>> rtl/qam_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle: -num * 2^FRAC_BITS / (2 * den)
module qam_div
    import qam_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_word    i_num,
    input  wire t_word    i_den,
    output t_div_res      o_res
);

    localparam logic [6:0]  LAST_BIT = 7'd127;
    localparam logic [33:0] Q_CAP    = 34'h2_0000_0000;
    localparam logic [33:0] Q_NEG    = 34'h0_8000_0000;
    localparam logic [33:0] Q_POS    = 34'h0_7FFF_FFFF;

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_dvd;
    logic [63:0]  r_d;
    logic [63:0]  r_rem;
    logic [33:0]  r_quot;
    logic         r_neg;

    logic [63:0]  w_rem2;
    logic         w_ge;
    logic [34:0]  w_q2;
    logic [33:0]  w_q;

    assign w_rem2 = {r_rem[62:0], r_dvd[127]};
    assign w_ge   = (w_rem2 >= r_d);
    assign w_q2   = {r_quot, w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= {64'b0, mag64(i_num)} << (FRAC_BITS - 1);
                r_d    <= mag64(i_den);
                r_rem  <= '0;
                r_quot <= '0;
                r_neg  <= (i_num[63] == i_den[63]);
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[126:0], 1'b0};
                r_rem  <= w_ge ? w_rem2 - r_d : w_rem2;
                // quotient held at 2^33 once it grows past
                r_quot <= (|w_q2[34:33]) ? Q_CAP : w_q2[33:0];
                r_cnt  <= r_cnt + 7'd1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // signed 32-bit result with saturation
    always_comb begin
        if (r_neg) begin
            o_res.sat = (r_quot > Q_NEG);
            w_q       = o_res.sat ? Q_NEG : r_quot;
            o_res.value = -w_q[31:0];
        end else begin
            o_res.sat = (r_quot > Q_POS);
            w_q       = o_res.sat ? Q_POS : r_quot;
            o_res.value = w_q[31:0];
        end
        o_res.done = r_done;
    end

endmodule

`default_nettype wire

>>> sim/quadric_accumulate_minimize_core_test.sv
`timescale 1ns / 1ps

module quadric_accumulate_minimize_core_test;
    import qam_pkg::*;

    typedef logic signed [63:0] t_wide;

    typedef struct packed {
        logic [2:0]         mode;
        logic [3:0]         coef_index;
        logic signed [31:0] value;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_item;

    typedef struct packed {
        logic signed [31:0] energy;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic               singular;
        logic               overflow;
    } t_answer;

    localparam int FRAC = 16;
    localparam t_wide WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

    logic i_clk;
    logic i_rst_n;

    qam_in_if  in_ch ();
    qam_out_if out_ch ();

    quadric_accumulate_minimize_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // model state
    t_wide   quad_coef [NUM_COEFS];
    logic    sat_hit;
    t_answer answers_due [$];

    int      mismatches;
    longint unsigned cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- arithmetic of the block ----------------
    function automatic logic [63:0] wmag(input t_wide x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic t_wide from_mag(input logic [63:0] m, input bit neg);
        if (m > 64'(WMAX)) begin
            sat_hit = 1'b1;
            m = 64'(WMAX);
        end
        return neg ? -t_wide'(m) : t_wide'(m);
    endfunction

    function automatic t_wide fx_mul(input t_wide x, input t_wide y);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, wmag(x)} * {64'd0, wmag(y)};
        if ((p >> (64 + FRAC)) != 0) begin
            sat_hit = 1'b1;
            m = 64'(WMAX);
        end else begin
            m = p[64 + FRAC - 1 -: 64];
        end
        return from_mag(m, x[63] != y[63]);
    endfunction

    function automatic t_wide fx_add(input t_wide x, input t_wide y);
        if (y > 0 && x > WMAX - y) begin
            sat_hit = 1'b1;
            return WMAX;
        end
        if (y < 0 && x < -WMAX - y) begin
            sat_hit = 1'b1;
            return -WMAX;
        end
        return x + y;
    endfunction

    function automatic t_wide coef_sat(input t_wide x);
        if (x > 64'sh7FFF_FFFF) begin
            sat_hit = 1'b1;
            return 64'sh7FFF_FFFF;
        end
        if (x < -64'sh8000_0000) begin
            sat_hit = 1'b1;
            return -64'sh8000_0000;
        end
        return x;
    endfunction

    function automatic logic [31:0] out_sat(input t_wide x);
        return 32'(coef_sat(x));
    endfunction

    // -num * 2^FRAC / (2 * den), quotient magnitude capped as the divider does
    function automatic logic [31:0] solve_axis(input t_wide num, input t_wide den);
        logic [127:0] n;
        logic [127:0] q;
        logic [63:0]  d;
        bit neg;
        n = {64'd0, wmag(num)} << (FRAC - 1);
        d = wmag(den);
        q = n / d;
        if (q > (128'd1 << 33)) q = 128'd1 << 33;
        neg = (num[63] == den[63]);
        if (neg) begin
            if (q > 128'h8000_0000) begin
                sat_hit = 1'b1;
                q = 128'h8000_0000;
            end
            return 32'(-q[31:0]) & 32'hFFFF_FFFF;
        end
        if (q > 128'h7FFF_FFFF) begin
            sat_hit = 1'b1;
            q = 128'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic t_wide mat_at(input int r, input int c);
        return quad_coef[3 * (r % 3) + (c % 3)];
    endfunction

    function automatic t_wide minor_of(input int r, input int c);
        t_wide a;
        t_wide b;
        a = fx_mul(mat_at(r + 1, c + 1), mat_at(r + 2, c + 2));
        b = fx_mul(mat_at(r + 1, c + 2), mat_at(r + 2, c + 1));
        return fx_add(a, -b);
    endfunction

    function automatic t_answer quadric_apply(input t_item it);
        t_answer ans;
        t_wide   pt [3];
        t_wide   acc;
        t_wide   row;
        t_wide   cof [3][3];
        t_wide   det;
        t_wide   num;
        logic [31:0] crd [3];
        ans = '0;
        sat_hit = 1'b0;
        pt[0] = it.px;
        pt[1] = it.py;
        pt[2] = it.pz;
        case (it.mode)
            MODE_CLEAR: for (int i = 0; i < NUM_COEFS; i++) quad_coef[i] = 0;
            MODE_ADD: if (it.coef_index < NUM_COEFS)
                quad_coef[it.coef_index] = coef_sat(quad_coef[it.coef_index] + it.value);
            MODE_SCALE: for (int i = 0; i < NUM_COEFS; i++)
                quad_coef[i] = coef_sat(fx_mul(quad_coef[i], t_wide'(it.value)));
            MODE_EVAL: begin
                acc = quad_coef[12];
                for (int i = 0; i < 3; i++) begin
                    row = 0;
                    for (int j = 0; j < 3; j++) row = fx_add(row, fx_mul(mat_at(i, j), pt[j]));
                    acc = fx_add(acc, fx_mul(pt[i], row));
                    acc = fx_add(acc, fx_mul(quad_coef[9 + i], pt[i]));
                end
                ans.energy = out_sat(acc);
            end
            MODE_MIN: begin
                det = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) cof[i][j] = minor_of(i, j);
                for (int j = 0; j < 3; j++) det = fx_add(det, fx_mul(mat_at(0, j), cof[0][j]));
                if (det == 0) begin
                    ans.singular = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        num = 0;
                        for (int j = 0; j < 3; j++)
                            num = fx_add(num, fx_mul(cof[j][i], quad_coef[9 + j]));
                        crd[i] = solve_axis(num, det);
                    end
                    ans.min_x = crd[0];
                    ans.min_y = crd[1];
                    ans.min_z = crd[2];
                end
            end
            default: ;
        endcase
        ans.overflow = sat_hit;
        return ans;
    endfunction

    // ---------------- driving and checking ----------------
    // valid stays high between back-to-back items; it drops only while idling or draining
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= it.mode;
        in_ch.coef_index <= it.coef_index;
        in_ch.value      <= it.value;
        in_ch.point_x    <= it.px;
        in_ch.point_y    <= it.py;
        in_ch.point_z    <= it.pz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        answers_due.push_back(quadric_apply(it));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    endtask

    // receiver stall control
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", out_ch.energy, 32'd0);
            end else begin
                want = answers_due.pop_front();
                if (out_ch.energy !== want.energy)
                    report_mismatch("energy", out_ch.energy, want.energy);
                if (out_ch.min_x !== want.min_x)
                    report_mismatch("min_x", out_ch.min_x, want.min_x);
                if (out_ch.min_y !== want.min_y)
                    report_mismatch("min_y", out_ch.min_y, want.min_y);
                if (out_ch.min_z !== want.min_z)
                    report_mismatch("min_z", out_ch.min_z, want.min_z);
                if (out_ch.singular !== want.singular)
                    report_mismatch("singular", 32'(out_ch.singular), 32'(want.singular));
                if (out_ch.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(out_ch.overflow), 32'(want.overflow));
            end
        end
    end

    // stop offering items and wait for every outstanding result
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_item make_item(input logic [2:0] m, input logic [3:0] ix,
                                        input logic [31:0] v, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        t_item it;
        it.mode = m;
        it.coef_index = ix;
        it.value = v;
        it.px = x;
        it.py = y;
        it.pz = z;
        return it;
    endfunction

    // moderate Q16.16 value, sometimes full range
    function automatic logic [31:0] rnd_fix();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
            default: return 32'($signed($urandom_range(32'h800000)) - 32'sh400000);
        endcase
    endfunction

    function automatic t_item rnd_item();
        t_item it;
        int    pick;
        it = make_item(MODE_ADD, 4'($urandom_range(12)), rnd_fix(), rnd_fix(), rnd_fix(),
                       rnd_fix());
        pick = $urandom_range(99);
        if (pick < 3) it.mode = MODE_CLEAR;
        else if (pick < 50) it.mode = MODE_ADD;
        else if (pick < 56) it.mode = MODE_SCALE;
        else if (pick < 80) it.mode = MODE_EVAL;
        else if (pick < 95) it.mode = MODE_MIN;
        else it.mode = 3'($urandom_range(7));
        if ($urandom_range(19) == 0) it.coef_index = 4'($urandom);
        if (it.mode == MODE_SCALE && $urandom_range(3) != 0)
            it.value = 32'($signed($urandom_range(32'h20000)));
        return it;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed;
        send_item(make_item(MODE_EVAL, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_item(make_item(MODE_MIN, 0, 0, 0, 0, 0));
        for (int i = 0; i < 3; i++)
            send_item(make_item(MODE_ADD, 4'(4 * i), 32'h0002_0000, 0, 0, 0));
        send_item(make_item(MODE_ADD, 9, 32'hFFFC_0000, 0, 0, 0));
        send_item(make_item(MODE_ADD, 12, 32'h7FFF_FFFF, 0, 0, 0));
        send_item(make_item(MODE_ADD, 12, 32'h7FFF_FFFF, 0, 0, 0));
        send_item(make_item(MODE_ADD, 4'd13, 32'hFFFF_FFFF, 0, 0, 0));
        send_item(make_item(MODE_ADD, 4'd15, 32'h8000_0000, 0, 0, 0));
        send_item(make_item(MODE_EVAL, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000));
        send_item(make_item(MODE_EVAL, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(MODE_MIN, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_SCALE, 0, 32'hFFFF_8000, 0, 0, 0));
        send_item(make_item(MODE_MIN, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_SCALE, 0, 32'h7FFF_FFFF, 0, 0, 0));
        send_item(make_item(MODE_MIN, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_SCALE, 0, 32'h8000_0000, 0, 0, 0));
        send_item(make_item(3'd5, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
        send_item(make_item(3'd6, 0, 0, 0, 0, 0));
        send_item(make_item(3'd7, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_ADD, 1, 32'h0000_0001, 0, 0, 0));
        send_item(make_item(MODE_MIN, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_random_phase(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++) send_item(rnd_item());
        drain();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 6; n++)
                send_item(make_item(MODE_ADD, 4'($urandom_range(12)), rnd_fix(), 0, 0, 0));
        join
        drain();
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NUM_COEFS; i++) quad_coef[i] = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_CLEAR;
        in_ch.coef_index = '0;
        in_ch.value = '0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.point_z = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(600, 0, 0);
        test_backpressure();
        test_random_phase(350, 81, 0);
        test_random_phase(350, 0, 81);
        test_random_phase(300, 13, 13);
        test_random_phase(300, 0, 0);

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
